FILE: hdl/eps_pkg.sv
package eps_pkg;

  // Fixed field widths
  localparam int NODE_W  = 10;
  localparam int FIDX_W  = 6;
  localparam int FEAT_W  = 16;
  localparam int CNT_W   = 7;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 40;
  localparam int SCORE_W = 41;

  // Parameter defaults
  localparam int NODES_MAX_DEF    = 1024;
  localparam int FEATURES_MAX_DEF = 64;

  // Reset value of the feature count register
  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  // Input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr;        // write one feature word
    logic             start;     // capture endpoints, clear accumulator
    logic             issue;     // read both rows at feat_idx
    logic [CNT_W-1:0] feat_idx;
    logic             load_out;  // move accumulator to output register
  } eps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pipe_busy;             // reads or products still in flight
  } eps_sts_t;

endpackage

FILE: hdl/eps_ram.sv
module eps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: hdl/eps_ctrl.sv
module eps_ctrl import eps_pkg::*; #(
  parameter int FEATURES_MAX = FEATURES_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output eps_cmd_t         cmd,
  input  eps_sts_t         sts
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam int CMP_W = 11;
  localparam logic [CMP_W-1:0] FMAX_CMP = CMP_W'(FEATURES_MAX);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] lim;

  // Effective feature count, clipped to the table width
  assign lim = ({{(CMP_W-CNT_W){1'b0}}, count_r} > FMAX_CMP) ? CNT_W'(FEATURES_MAX) : count_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.feat_idx  = j_r;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == ACT_QUERY) begin
            cmd.start = 1'b1;
            lim_nxt   = lim;
            j_nxt     = '0;
            state_nxt = (lim == '0) ? ST_DRAIN : ST_RUN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        j_nxt     = j_r + CNT_W'(1);
        if ((j_r + CNT_W'(1)) == lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the pipe to empty and the output register to free up
        if (!sts.pipe_busy && (!out_valid_r || !out_stall)) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lim_r       <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lim_r       <= lim_nxt;
      j_r         <= j_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/eps_dp.sv
module eps_dp import eps_pkg::*; #(
  parameter int NODES_MAX    = NODES_MAX_DEF,
  parameter int FEATURES_MAX = FEATURES_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  eps_cmd_t                  cmd,
  output eps_sts_t                  sts,
  input  logic [NODE_W-1:0]         in_write_node,
  input  logic [FIDX_W-1:0]         in_write_feature,
  input  logic signed [FEAT_W-1:0]  in_write_value,
  input  logic [NODE_W-1:0]         in_first_node,
  input  logic [NODE_W-1:0]         in_second_node,
  output logic signed [SCORE_W-1:0] out_score
);

  localparam int NW    = $clog2(NODES_MAX);
  localparam int FW    = (FEATURES_MAX > 1) ? $clog2(FEATURES_MAX) : 1;
  localparam int AW    = NW + FW;
  localparam int DEPTH = NODES_MAX << FW;
  localparam int NX_W  = 17;
  localparam int FX_W  = 11;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [NX_W-1:0] wr_node_x, a_node_x, b_node_x;
  logic [FX_W-1:0] wr_feat_x, rd_feat_x;
  logic            wr_en;
  logic [AW-1:0]   waddr, raddr_a, raddr_b;
  logic [FEAT_W-1:0] rdata_a, rdata_b;

  logic [NW-1:0] a_node_r, b_node_r;
  logic          a_zero_r, b_zero_r;
  logic          rd_v_r, prod_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [FEAT_W-1:0]  op_a, op_b;
  logic signed [SCORE_W-1:0] score_r;

  assign wr_node_x = NX_W'(in_write_node);
  assign wr_feat_x = FX_W'(in_write_feature);
  assign a_node_x  = NX_W'(in_first_node);
  assign b_node_x  = NX_W'(in_second_node);
  assign rd_feat_x = FX_W'(cmd.feat_idx);

  // Out-of-range writes are dropped
  assign wr_en = cmd.wr && (wr_node_x < NX_W'(NODES_MAX)) && (wr_feat_x < FX_W'(FEATURES_MAX));
  assign waddr   = {wr_node_x[NW-1:0], wr_feat_x[FW-1:0]};
  assign raddr_a = {a_node_r, rd_feat_x[FW-1:0]};
  assign raddr_b = {b_node_r, rd_feat_x[FW-1:0]};

  eps_ram #(
    .WIDTH (FEAT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (waddr),
    .wdata   (in_write_value),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Endpoint capture; an out-of-range node reads as all zeros
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_node_r <= a_node_x[NW-1:0];
      b_node_r <= b_node_x[NW-1:0];
      a_zero_r <= !(a_node_x < NX_W'(NODES_MAX));
      b_zero_r <= !(b_node_x < NX_W'(NODES_MAX));
    end
  end

  assign op_a = a_zero_r ? '0 : $signed(rdata_a);
  assign op_b = b_zero_r ? '0 : $signed(rdata_b);

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Saturating accumulate
  assign sum     = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(prod_r);
  assign acc_sat = (sum[ACC_W] != sum[ACC_W-1]) ? (sum[ACC_W] ? ACC_MIN : ACC_MAX)
                                                : sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
      if (cmd.start) begin
        acc_r <= '0;
      end else if (prod_v_r) begin
        acc_r <= acc_sat;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      score_r <= SCORE_W'(acc_r);
    end
  end

  assign sts.pipe_busy = rd_v_r || prod_v_r;
  assign out_score     = score_r;

endmodule

FILE: hdl/edge_pair_dot_product_scorer.sv
// Edge pair dot-product scorer.
// Input channel (in_valid / in_stall): in_action 0 writes in_write_value into
// the feature table at (in_write_node, in_write_feature); in_action 1 scores
// the edge (in_first_node, in_second_node). Writes do not stall the input and give no
// result. A query reads both feature rows from one dual-read table, one
// feature per cycle, through a multiply stage into a saturating accumulator.
// With n = min(feature_count, FEATURES_MAX), a query holds the input stalled
// while it issues its n feature reads, drains the pipe and waits for the
// output register to free up; queries run one at a time.
// Output channel (out_valid / out_stall): one out_score per query, in order.
// The score waits in an output register, so the next request is taken while
// the receiver stalls; a later query only holds at its end until that register
// frees up.
// cfg_we / cfg_data write feature_count; write it only while idle.
// Reset clears control state and sets feature_count to 64; the table is not
// cleared, so each entry must be written before a query reads it.
module edge_pair_dot_product_scorer import eps_pkg::*; #(
  parameter int NODES_MAX    = NODES_MAX_DEF,
  parameter int FEATURES_MAX = FEATURES_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [NODE_W-1:0]         in_write_node,
  input  logic [FIDX_W-1:0]         in_write_feature,
  input  logic signed [FEAT_W-1:0]  in_write_value,
  input  logic [NODE_W-1:0]         in_first_node,
  input  logic [NODE_W-1:0]         in_second_node,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SCORE_W-1:0] out_score,
  input  logic                      cfg_we,
  input  logic [CNT_W-1:0]          cfg_data
);

  eps_cmd_t cmd;
  eps_sts_t sts;

  eps_ctrl #(
    .FEATURES_MAX (FEATURES_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  eps_dp #(
    .NODES_MAX    (NODES_MAX),
    .FEATURES_MAX (FEATURES_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_write_node    (in_write_node),
    .in_write_feature (in_write_feature),
    .in_write_value   (in_write_value),
    .in_first_node    (in_first_node),
    .in_second_node   (in_second_node),
    .out_score        (out_score)
  );

endmodule

FILE: hdl/eps_checker.sv
module eps_checker import eps_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_action,
  input logic               out_valid,
  input logic               out_stall,
  input logic [SCORE_W-1:0] out_score
);

  // No score is pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled score holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score))
    else $error("stalled score changed or dropped");

  // A query keeps the input side busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_QUERY) |=> in_stall)
    else $error("input taken right after a query request");

  // A table write leaves the input free to take the next request
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_WRITE) |=> !in_stall)
    else $error("input stalled after a write request");

  // Scores are sign-extended from the accumulator width
  a_score_sext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score[SCORE_W-1] == out_score[SCORE_W-2])
    else $error("score not sign-extended");

endmodule

bind edge_pair_dot_product_scorer eps_checker u_eps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_score (out_score)
);

FILE: tb/sv/edge_pair_dot_product_scorer_tb.sv
module edge_pair_dot_product_scorer_tb;
  import eps_pkg::*;

  localparam int NODES  = NODES_MAX_DEF;
  localparam int FEATS  = FEATURES_MAX_DEF;
  localparam int POOL_N = 6;

  localparam logic signed [FEAT_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [FEAT_W-1:0] VAL_MAX = 16'sh7FFF;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -ACC_HI - 64'sd1;

  // one request on the input channel
  typedef struct {
    logic                     action;
    logic [NODE_W-1:0]        wnode;
    logic [FIDX_W-1:0]        wfeat;
    logic signed [FEAT_W-1:0] wval;
    logic [NODE_W-1:0]        node_a;
    logic [NODE_W-1:0]        node_b;
  } edge_req_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_action = 1'b0;
  logic [NODE_W-1:0]         in_write_node = '0;
  logic [FIDX_W-1:0]         in_write_feature = '0;
  logic signed [FEAT_W-1:0]  in_write_value = '0;
  logic [NODE_W-1:0]         in_first_node = '0;
  logic [NODE_W-1:0]         in_second_node = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SCORE_W-1:0] out_score;
  logic                      cfg_we = 1'b0;
  logic [CNT_W-1:0]          cfg_data = '0;

  // stimulus side
  edge_req_t         req_fifo[$];
  bit                gen_written [NODES][FEATS];
  logic [NODE_W-1:0] pool [POOL_N];
  int                sent_cnt = 0;
  int                taken_cnt = 0;
  int                tx_gap = 0;
  int                rx_gap = 0;
  int                hold_left = 0;
  bit                hold_done = 1'b0;
  bit                calm = 1'b0;

  // predictor side
  logic signed [FEAT_W-1:0]  feat_mem [NODES][FEATS];
  logic [CNT_W-1:0]          feat_count = COUNT_RESET;
  logic signed [SCORE_W-1:0] pending_scores[$];
  int                        scores_seen = 0;
  int                        err_cnt = 0;

  edge_pair_dot_product_scorer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_write_node    (in_write_node),
    .in_write_feature (in_write_feature),
    .in_write_value   (in_write_value),
    .in_first_node    (in_first_node),
    .in_second_node   (in_second_node),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_score        (out_score),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // dot product of two stored rows, saturating at the 40-bit limits
  function automatic logic signed [SCORE_W-1:0] dot_score(input logic [NODE_W-1:0] a,
                                                          input logic [NODE_W-1:0] b);
    longint acc;
    int     n;
    acc = 0;
    n = (feat_count > FEATS) ? FEATS : int'(feat_count);
    for (int j = 0; j < n; j++) begin
      acc += longint'(feat_mem[a][j]) * longint'(feat_mem[b][j]);
      if (acc > ACC_HI) acc = ACC_HI;
      else if (acc < ACC_LO) acc = ACC_LO;
    end
    return acc[SCORE_W-1:0];
  endfunction

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("%s", msg);
    err_cnt++;
  endtask

  // request driver: a stalled request holds, otherwise offer the next or idle
  always @(negedge clk) begin
    edge_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_cnt != sent_cnt) begin
      // still waiting for acceptance
    end else begin
      if (!calm && tx_gap == 0 && req_fifo.size() > 0 && $urandom_range(0, 9) == 0)
        tx_gap = $urandom_range(1, 19);
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (req_fifo.size() > 0) begin
        r = req_fifo.pop_front();
        in_action        <= r.action;
        in_write_node    <= r.wnode;
        in_write_feature <= r.wfeat;
        in_write_value   <= r.wval;
        in_first_node    <= r.node_a;
        in_second_node   <= r.node_b;
        in_valid         <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: one long hold-off once traffic is flowing, else random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && scores_seen >= 30) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // score checker and predictor update
  always @(posedge clk) begin
    logic signed [SCORE_W-1:0] want;
    if (!rst_n) begin
      feat_count = COUNT_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        scores_seen++;
        if (pending_scores.size() == 0) begin
          note_error($sformatf("score %0d with no query outstanding", out_score));
        end else begin
          want = pending_scores.pop_front();
          if (out_score !== want)
            note_error($sformatf("score mismatch: expected %0d got %0d", want, out_score));
        end
      end
      if (in_valid && !in_stall) begin
        taken_cnt++;
        if (in_action == ACT_WRITE)
          feat_mem[in_write_node][in_write_feature] = in_write_value;
        else
          pending_scores.push_back(dot_score(in_first_node, in_second_node));
      end
      if (cfg_we) feat_count = cfg_data;
    end
  end

  // ---- stimulus helpers ----
  task automatic push_write(input logic [NODE_W-1:0] node, input logic [FIDX_W-1:0] feat,
                            input logic signed [FEAT_W-1:0] v);
    edge_req_t r;
    r.action = ACT_WRITE;
    r.wnode  = node;
    r.wfeat  = feat;
    r.wval   = v;
    r.node_a = NODE_W'($urandom);
    r.node_b = NODE_W'($urandom);
    gen_written[node][feat] = 1'b1;
    req_fifo.push_back(r);
  endtask

  task automatic push_query(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    edge_req_t r;
    r.action = ACT_QUERY;
    r.wnode  = NODE_W'($urandom);
    r.wfeat  = FIDX_W'($urandom);
    r.wval   = FEAT_W'($urandom);
    r.node_a = a;
    r.node_b = b;
    req_fifo.push_back(r);
  endtask

  function automatic logic signed [FEAT_W-1:0] rand_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return VAL_MIN;
    if (roll == 1) return VAL_MAX;
    return FEAT_W'($urandom);
  endfunction

  function automatic bit row_ready(input logic [NODE_W-1:0] node, input int n);
    for (int j = 0; j < n; j++)
      if (!gen_written[node][j]) return 1'b0;
    return 1'b1;
  endfunction

  // wait until every request is taken and every score has come back
  task automatic wait_drained();
    while (!(req_fifo.size() == 0 && sent_cnt == taken_cnt && pending_scores.size() == 0))
      @(posedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] v);
    wait_drained();
    // let a trailing write or query wind down
    repeat (70) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly row fills then queries on filled rows, with stray writes as noise
  task automatic random_phase(input int count_val, input int len);
    int                n;
    int                lim;
    int                roll;
    logic [NODE_W-1:0] node;
    logic [FIDX_W-1:0] feat;
    logic [NODE_W-1:0] ready[$];
    n = (count_val > FEATS) ? FEATS : count_val;
    lim = (n == 0) ? FEATS : n;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      ready.delete();
      for (int k = 0; k < POOL_N; k++)
        if (row_ready(pool[k], n)) ready.push_back(pool[k]);
      if (n == 0 && roll >= 55) begin
        // nothing is read, so any endpoints will do
        push_query(NODE_W'($urandom), NODE_W'($urandom));
      end else if (roll < 10) begin
        push_write(NODE_W'($urandom), FIDX_W'($urandom), rand_value());
      end else if (roll < 55 || ready.size() == 0) begin
        node = pool[$urandom_range(0, POOL_N - 1)];
        if ($urandom_range(0, 9) < 7) begin
          // favor finishing the first incomplete row
          for (int k = 0; k < POOL_N; k++)
            if (!row_ready(pool[k], lim)) begin
              node = pool[k];
              break;
            end
        end
        feat = FIDX_W'($urandom_range(0, lim - 1));
        if ($urandom_range(0, 9) < 7) begin
          for (int j = 0; j < lim; j++)
            if (!gen_written[node][j]) begin
              feat = FIDX_W'(j);
              break;
            end
        end
        push_write(node, feat, rand_value());
      end else begin
        push_query(ready[$urandom_range(0, ready.size() - 1)],
                   ready[$urandom_range(0, ready.size() - 1)]);
      end
    end
  endtask

  // ---- main sequence ----
  initial begin
    int phase_cnt [8];
    int phase_len [8];
    phase_cnt = '{1, 4, 127, 9, 0, 64, 33, 2};
    phase_len = '{80, 90, 200, 70, 40, 130, 70, 60};
    pool[0] = '0;
    pool[1] = NODE_W'(NODES - 1);
    for (int k = 2; k < POOL_N; k++) pool[k] = NODE_W'($urandom_range(1, NODES - 2));
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // two features: extreme products and both signs
    set_count(2);
    push_write(0, 0, VAL_MIN);
    push_write(0, 1, VAL_MIN);
    push_write(NODE_W'(NODES - 1), 0, VAL_MAX);
    push_write(NODE_W'(NODES - 1), 1, VAL_MAX);
    push_write(512, 0, 16'sd0);
    push_write(512, 1, 16'sd1);
    push_write(341, FIDX_W'(FEATS - 1), 16'sh5555);
    push_query(0, 0);
    push_query(NODE_W'(NODES - 1), NODE_W'(NODES - 1));
    push_query(0, NODE_W'(NODES - 1));
    push_query(512, NODE_W'(NODES - 1));

    // zero count sums nothing, even over unwritten rows
    set_count(0);
    push_query(341, 682);
    push_query(0, NODE_W'(NODES - 1));

    // single feature, then overwrite and query again
    set_count(1);
    push_query(NODE_W'(NODES - 1), 0);
    push_write(NODE_W'(NODES - 1), 0, 16'sd0);
    push_query(NODE_W'(NODES - 1), 0);

    for (int p = 0; p < 8; p++) begin
      if (p == 7) calm = 1'b1;
      set_count(CNT_W'(phase_cnt[p]));
      random_phase(phase_cnt[p], phase_len[p]);
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (err_cnt == 0 && pending_scores.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/eps_pkg.sv
hdl/eps_ram.sv
hdl/eps_ctrl.sv
hdl/eps_dp.sv
hdl/edge_pair_dot_product_scorer.sv
hdl/eps_checker.sv
tb/sv/edge_pair_dot_product_scorer_tb.sv
